>>> rtl/core/vcskm_pkg.sv
// Shared types and constants for the video crop, sample and key mapper.
// Used by every file of the block but vcskm_chan_if; depends on nothing.
package vcskm_pkg;

   localparam int CoordW   = 12;
   localparam int DimW     = 13;
   localparam int PctW     = 7;
   localparam int KeyW     = 11;
   localparam int ColorW   = 8;
   localparam int SumW     = 10;
   localparam int CsrIdxW  = 4;
   localparam int CsrDataW = 13;

   // percent products and exact divide by 100 through a reciprocal
   localparam int ProdW      = 20;
   localparam int RecipW     = 21;
   localparam int RecipShift = 27;
   localparam int QuotW      = 14;
   localparam logic [RecipW-1:0] RecipK = 21'd1342178;
   localparam logic [PctW-1:0] PctFull = 7'd100;

   // signed geometry width and divider shape
   localparam int GeoW      = 16;
   localparam int DivW      = 16;
   localparam int RemW      = 7;
   localparam int GeoStages = 6;
   localparam int DivStages = 4;
   localparam int DivSteps  = DivW / DivStages;
   localparam int NumStages = GeoStages + DivStages + 1;

   localparam logic [CsrIdxW-1:0] CsrBufferWidth   = 4'd0;
   localparam logic [CsrIdxW-1:0] CsrBufferHeight  = 4'd1;
   localparam logic [CsrIdxW-1:0] CsrCropLeft      = 4'd2;
   localparam logic [CsrIdxW-1:0] CsrCropRight     = 4'd3;
   localparam logic [CsrIdxW-1:0] CsrCropTop       = 4'd4;
   localparam logic [CsrIdxW-1:0] CsrCropBottom    = 4'd5;
   localparam logic [CsrIdxW-1:0] CsrKeyLevel      = 4'd6;
   localparam logic [CsrIdxW-1:0] CsrSampleSpacing = 4'd7;

   typedef struct packed {
      logic [DimW-1:0]   frame_width;
      logic [DimW-1:0]   frame_height;
      logic [CoordW-1:0] src_x;
      logic [CoordW-1:0] src_y;
      logic [ColorW-1:0] src_red;
      logic [ColorW-1:0] src_green;
      logic [ColorW-1:0] src_blue;
   } req_type;

   typedef struct packed {
      logic [CoordW-1:0] dest_x;
      logic [CoordW-1:0] dest_y;
      logic [ColorW-1:0] out_red;
      logic [ColorW-1:0] out_green;
      logic [ColorW-1:0] out_blue;
   } rsp_type;

   // buffer sizes already clamped to the maximum dimension
   typedef struct packed {
      logic [DimW-1:0]        buf_w;
      logic [DimW-1:0]        buf_h;
      logic [PctW-1:0]        crop_left;
      logic [PctW-1:0]        crop_right;
      logic [PctW-1:0]        crop_top;
      logic [PctW-1:0]        crop_bottom;
      logic signed [KeyW-1:0] key_level;
      logic [PctW-1:0]        spacing;
   } cfg_type;

   typedef struct packed {
      logic              keep;
      logic              ok_n;
      logic              neg_s;
      logic [GeoW-1:0]   dx_n;
      logic [GeoW-1:0]   dy_n;
      logic [DivW-1:0]   ddx;
      logic [DivW-1:0]   ddy;
      logic [ColorW-1:0] red;
      logic [ColorW-1:0] green;
      logic [ColorW-1:0] blue;
   } geo_type;

   typedef struct packed {
      geo_type         side;
      logic [DivW-1:0] quot_x;
      logic [DivW-1:0] quot_y;
      logic [RemW-1:0] rem_x;
      logic [RemW-1:0] rem_y;
   } div_res_type;

endpackage

>>> rtl/core/vcskm_chan_if.sv
// Valid/ready channel carrying one beat of a packed payload.
// Payload type is set per instance; no package dependency.
interface vcskm_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/vcskm_geom.sv
// Front pipeline: frame/key checks, crop offsets, centering and mode terms.
// Six register stages; depends on vcskm_pkg.
module vcskm_geom (
   input  logic                               clock,
   input  vcskm_pkg::cfg_type                 cfg,
   input  logic [vcskm_pkg::GeoStages-1:0]    stage_en,
   input  vcskm_pkg::req_type                 req_data,
   output vcskm_pkg::geo_type                 geo
);

   typedef struct packed {
      logic [vcskm_pkg::CoordW-1:0] px;
      logic [vcskm_pkg::CoordW-1:0] py;
      logic [vcskm_pkg::DimW-1:0]   fw;
      logic [vcskm_pkg::DimW-1:0]   fh;
      logic [vcskm_pkg::ColorW-1:0] red;
      logic [vcskm_pkg::ColorW-1:0] green;
      logic [vcskm_pkg::ColorW-1:0] blue;
      logic                         keep;
      logic [vcskm_pkg::ProdW-1:0]  p_xoff;
      logic [vcskm_pkg::ProdW-1:0]  p_yoff;
      logic [vcskm_pkg::ProdW-1:0]  p_xt;
      logic [vcskm_pkg::ProdW-1:0]  p_yt;
      logic                         xt_neg;
      logic                         yt_neg;
   } st1_type;

   typedef struct packed {
      logic [vcskm_pkg::CoordW-1:0] px;
      logic [vcskm_pkg::CoordW-1:0] py;
      logic [vcskm_pkg::DimW-1:0]   fw;
      logic [vcskm_pkg::DimW-1:0]   fh;
      logic [vcskm_pkg::ColorW-1:0] red;
      logic [vcskm_pkg::ColorW-1:0] green;
      logic [vcskm_pkg::ColorW-1:0] blue;
      logic                         keep;
      logic [vcskm_pkg::QuotW-1:0]  xoff;
      logic [vcskm_pkg::QuotW-1:0]  yoff;
      logic [vcskm_pkg::QuotW-1:0]  xt_q;
      logic [vcskm_pkg::QuotW-1:0]  yt_q;
      logic                         xt_neg;
      logic                         yt_neg;
   } st2_type;

   typedef struct packed {
      logic [vcskm_pkg::CoordW-1:0] px;
      logic [vcskm_pkg::CoordW-1:0] py;
      logic [vcskm_pkg::ColorW-1:0] red;
      logic [vcskm_pkg::ColorW-1:0] green;
      logic [vcskm_pkg::ColorW-1:0] blue;
      logic                         keep;
      logic [vcskm_pkg::QuotW-1:0]  xoff;
      logic [vcskm_pkg::GeoW-1:0]   cw;
      logic [vcskm_pkg::GeoW-1:0]   ch;
      logic [vcskm_pkg::GeoW-1:0]   ytail;
   } st3_type;

   typedef struct packed {
      logic [vcskm_pkg::CoordW-1:0] px;
      logic [vcskm_pkg::CoordW-1:0] py;
      logic [vcskm_pkg::ColorW-1:0] red;
      logic [vcskm_pkg::ColorW-1:0] green;
      logic [vcskm_pkg::ColorW-1:0] blue;
      logic                         keep;
      logic [vcskm_pkg::GeoW-1:0]   sx;
      logic [vcskm_pkg::GeoW-1:0]   sy;
      logic [vcskm_pkg::GeoW-1:0]   minw;
      logic [vcskm_pkg::GeoW-1:0]   minh;
      logic [vcskm_pkg::GeoW-1:0]   x;
      logic [vcskm_pkg::GeoW-1:0]   y;
   } st4_type;

   function automatic logic [vcskm_pkg::QuotW-1:0] div100(
      input logic [vcskm_pkg::ProdW-1:0] p
   );
      logic [vcskm_pkg::ProdW+vcskm_pkg::RecipW-1:0] full;
      full = (vcskm_pkg::ProdW + vcskm_pkg::RecipW)'(p)
           * (vcskm_pkg::ProdW + vcskm_pkg::RecipW)'(vcskm_pkg::RecipK);
      return full[vcskm_pkg::RecipShift +: vcskm_pkg::QuotW];
   endfunction

   vcskm_pkg::req_type s0_ff;
   st1_type            s1_ff, s1_in;
   st2_type            s2_ff, s2_in;
   st3_type            s3_ff, s3_in;
   st4_type            s4_ff, s4_in;
   vcskm_pkg::geo_type s5_ff, s5_in;

   // stage 1: range and key tests, percent products
   logic [vcskm_pkg::SumW-1:0] sum1;
   logic signed [vcskm_pkg::KeyW:0] sum1_s, key1_s;
   logic [vcskm_pkg::PctW-1:0] xt_mag1, yt_mag1;

   always_comb begin
      sum1 = {2'b00, s0_ff.src_red} + {2'b00, s0_ff.src_green} + {2'b00, s0_ff.src_blue};
      sum1_s = $signed({2'b00, sum1});
      key1_s = $signed({cfg.key_level[vcskm_pkg::KeyW-1], cfg.key_level});
      xt_mag1 = (cfg.crop_right > vcskm_pkg::PctFull) ? cfg.crop_right - vcskm_pkg::PctFull
                                                      : vcskm_pkg::PctFull - cfg.crop_right;
      yt_mag1 = (cfg.crop_top > vcskm_pkg::PctFull) ? cfg.crop_top - vcskm_pkg::PctFull
                                                    : vcskm_pkg::PctFull - cfg.crop_top;
      s1_in.px     = s0_ff.src_x;
      s1_in.py     = s0_ff.src_y;
      s1_in.fw     = s0_ff.frame_width;
      s1_in.fh     = s0_ff.frame_height;
      s1_in.red    = s0_ff.src_red;
      s1_in.green  = s0_ff.src_green;
      s1_in.blue   = s0_ff.src_blue;
      s1_in.keep   = ({1'b0, s0_ff.src_x} < s0_ff.frame_width)
                  && ({1'b0, s0_ff.src_y} < s0_ff.frame_height)
                  && !(sum1_s <= key1_s);
      s1_in.p_xoff = vcskm_pkg::ProdW'(cfg.crop_left) * vcskm_pkg::ProdW'(s0_ff.frame_width);
      s1_in.p_yoff = vcskm_pkg::ProdW'(cfg.crop_bottom) * vcskm_pkg::ProdW'(s0_ff.frame_height);
      s1_in.p_xt   = vcskm_pkg::ProdW'(xt_mag1) * vcskm_pkg::ProdW'(s0_ff.frame_width);
      s1_in.p_yt   = vcskm_pkg::ProdW'(yt_mag1) * vcskm_pkg::ProdW'(s0_ff.frame_height);
      s1_in.xt_neg = cfg.crop_right > vcskm_pkg::PctFull;
      s1_in.yt_neg = cfg.crop_top > vcskm_pkg::PctFull;
   end

   // stage 2: divide the products by 100
   always_comb begin
      s2_in.px     = s1_ff.px;
      s2_in.py     = s1_ff.py;
      s2_in.fw     = s1_ff.fw;
      s2_in.fh     = s1_ff.fh;
      s2_in.red    = s1_ff.red;
      s2_in.green  = s1_ff.green;
      s2_in.blue   = s1_ff.blue;
      s2_in.keep   = s1_ff.keep;
      s2_in.xoff   = div100(s1_ff.p_xoff);
      s2_in.yoff   = div100(s1_ff.p_yoff);
      s2_in.xt_q   = div100(s1_ff.p_xt);
      s2_in.yt_q   = div100(s1_ff.p_yt);
      s2_in.xt_neg = s1_ff.xt_neg;
      s2_in.yt_neg = s1_ff.yt_neg;
   end

   // stage 3: cropped size, signed tail
   logic signed [vcskm_pkg::GeoW-1:0] fw3, fh3, xoff3, yoff3, xq3, yq3;

   always_comb begin
      fw3   = $signed({3'b000, s2_ff.fw});
      fh3   = $signed({3'b000, s2_ff.fh});
      xoff3 = $signed({2'b00, s2_ff.xoff});
      yoff3 = $signed({2'b00, s2_ff.yoff});
      xq3   = $signed({2'b00, s2_ff.xt_q});
      yq3   = $signed({2'b00, s2_ff.yt_q});
      s3_in.px    = s2_ff.px;
      s3_in.py    = s2_ff.py;
      s3_in.red   = s2_ff.red;
      s3_in.green = s2_ff.green;
      s3_in.blue  = s2_ff.blue;
      s3_in.keep  = s2_ff.keep;
      s3_in.xoff  = s2_ff.xoff;
      s3_in.cw    = s2_ff.xt_neg ? fw3 - xoff3 + xq3 : fw3 - xoff3 - xq3;
      s3_in.ch    = s2_ff.yt_neg ? fh3 - yoff3 + yq3 : fh3 - yoff3 - yq3;
      s3_in.ytail = s2_ff.yt_neg ? -yq3 : yq3;
   end

   // stage 4: centering origin, clipped size, normal-mode coordinates
   logic signed [vcskm_pkg::GeoW-1:0] bw4, bh4, cw4, ch4, dw4, dh4, sx4, sy4;

   always_comb begin
      bw4 = $signed({3'b000, cfg.buf_w});
      bh4 = $signed({3'b000, cfg.buf_h});
      cw4 = $signed(s3_ff.cw);
      ch4 = $signed(s3_ff.ch);
      dw4 = bw4 - cw4;
      dh4 = bh4 - ch4;
      // halve, truncating toward zero
      sx4 = (dw4 >>> 1) + $signed({{(vcskm_pkg::GeoW-1){1'b0}}, dw4[vcskm_pkg::GeoW-1] & dw4[0]});
      sy4 = (dh4 >>> 1) + $signed({{(vcskm_pkg::GeoW-1){1'b0}}, dh4[vcskm_pkg::GeoW-1] & dh4[0]});
      s4_in.px    = s3_ff.px;
      s4_in.py    = s3_ff.py;
      s4_in.red   = s3_ff.red;
      s4_in.green = s3_ff.green;
      s4_in.blue  = s3_ff.blue;
      s4_in.keep  = s3_ff.keep;
      s4_in.sx    = sx4;
      s4_in.sy    = sy4;
      s4_in.minw  = (bw4 < cw4) ? bw4 : cw4;
      s4_in.minh  = (bh4 < ch4) ? bh4 : ch4;
      s4_in.x     = $signed({4'b0000, s3_ff.px}) - $signed({2'b00, s3_ff.xoff});
      s4_in.y     = ch4 - 16'sd1 + $signed(s3_ff.ytail) - $signed({4'b0000, s3_ff.py});
   end

   // stage 5: normal-mode window test and destination, sample-mode deltas
   logic signed [vcskm_pkg::GeoW-1:0] x5, y5, sx5, sy5, ddx5, ddy5;

   always_comb begin
      x5   = $signed(s4_ff.x);
      y5   = $signed(s4_ff.y);
      sx5  = $signed(s4_ff.sx);
      sy5  = $signed(s4_ff.sy);
      ddx5 = $signed({4'b0000, s4_ff.px}) - sx5;
      ddy5 = $signed({4'b0000, s4_ff.py}) - sy5;
      s5_in.keep  = s4_ff.keep;
      s5_in.ok_n  = !x5[vcskm_pkg::GeoW-1] && (x5 < $signed(s4_ff.minw))
                 && !y5[vcskm_pkg::GeoW-1] && (y5 < $signed(s4_ff.minh));
      s5_in.dx_n  = x5 + ((sx5 > 16'sd0) ? sx5 : 16'sd0);
      s5_in.dy_n  = y5 + ((sy5 > 16'sd0) ? sy5 : 16'sd0);
      s5_in.ddx   = ddx5;
      s5_in.ddy   = ddy5;
      s5_in.neg_s = ddx5[vcskm_pkg::GeoW-1] || ddy5[vcskm_pkg::GeoW-1];
      s5_in.red   = s4_ff.red;
      s5_in.green = s4_ff.green;
      s5_in.blue  = s4_ff.blue;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) s0_ff <= req_data;
      if (stage_en[1]) s1_ff <= s1_in;
      if (stage_en[2]) s2_ff <= s2_in;
      if (stage_en[3]) s3_ff <= s3_in;
      if (stage_en[4]) s4_ff <= s4_in;
      if (stage_en[5]) s5_ff <= s5_in;
   end

   assign geo = s5_ff;

endmodule

>>> rtl/core/vcskm_div.sv
// Pipelined radix-2 restoring divider for both sample-mode deltas.
// DivStages register stages of DivSteps bits each; depends on vcskm_pkg.
module vcskm_div (
   input  logic                               clock,
   input  logic [vcskm_pkg::RemW-1:0]         divisor,
   input  logic [vcskm_pkg::DivStages-1:0]    stage_en,
   input  vcskm_pkg::geo_type                 geo_in,
   output vcskm_pkg::div_res_type             res
);

   typedef struct packed {
      logic [vcskm_pkg::RemW-1:0] rem;
      logic [vcskm_pkg::DivW-1:0] num;
   } dstate_type;

   function automatic dstate_type div_steps(
      input dstate_type                 s,
      input logic [vcskm_pkg::RemW-1:0] d
   );
      dstate_type                 r;
      logic [vcskm_pkg::RemW:0]   t;
      r = s;
      for (int i = 0; i < vcskm_pkg::DivSteps; i++) begin
         t = {r.rem, r.num[vcskm_pkg::DivW-1]};
         if (t >= {1'b0, d}) begin
            r.rem = vcskm_pkg::RemW'(t - {1'b0, d});
            r.num = {r.num[vcskm_pkg::DivW-2:0], 1'b1};
         end else begin
            r.rem = t[vcskm_pkg::RemW-1:0];
            r.num = {r.num[vcskm_pkg::DivW-2:0], 1'b0};
         end
      end
      return r;
   endfunction

   dstate_type         x_ff    [vcskm_pkg::DivStages];
   dstate_type         y_ff    [vcskm_pkg::DivStages];
   dstate_type         x_in    [vcskm_pkg::DivStages];
   dstate_type         y_in    [vcskm_pkg::DivStages];
   vcskm_pkg::geo_type side_ff [vcskm_pkg::DivStages];
   vcskm_pkg::geo_type side_in [vcskm_pkg::DivStages];

   always_comb begin
      for (int j = 0; j < vcskm_pkg::DivStages; j++) begin
         if (j == 0) begin
            x_in[j]    = div_steps({{vcskm_pkg::RemW{1'b0}}, geo_in.ddx}, divisor);
            y_in[j]    = div_steps({{vcskm_pkg::RemW{1'b0}}, geo_in.ddy}, divisor);
            side_in[j] = geo_in;
         end else begin
            x_in[j]    = div_steps(x_ff[j-1], divisor);
            y_in[j]    = div_steps(y_ff[j-1], divisor);
            side_in[j] = side_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < vcskm_pkg::DivStages; j++) begin
         if (stage_en[j]) begin
            x_ff[j]    <= x_in[j];
            y_ff[j]    <= y_in[j];
            side_ff[j] <= side_in[j];
         end
      end
   end

   assign res.side   = side_ff[vcskm_pkg::DivStages-1];
   assign res.quot_x = x_ff[vcskm_pkg::DivStages-1].num;
   assign res.quot_y = y_ff[vcskm_pkg::DivStages-1].num;
   assign res.rem_x  = x_ff[vcskm_pkg::DivStages-1].rem;
   assign res.rem_y  = y_ff[vcskm_pkg::DivStages-1].rem;

endmodule

>>> rtl/core/video_crop_sample_key_mapper_unit.sv
// Top level of the video crop, sample and key mapper: registers, pipeline
// control, final test and output register. Depends on vcskm_pkg,
// vcskm_chan_if, vcskm_geom and vcskm_div.
//
// Usage:
//  req_if carries one source pixel per beat with its frame size; rsp_if
//  carries at most one destination pixel per request beat, in order.
//  Pixels outside the frame, keyed out, outside the crop window (spacing
//  zero) or off the sample grid (spacing nonzero) produce no response beat.
//  csr_wr_en/csr_index/csr_wdata write the eight setup registers; write
//  them only while the pipeline is empty.
//  Throughput: one pixel per clock while rsp_if.ready holds. A kept pixel
//  passes through eleven register stages on its way to rsp_if:
//  six for crop geometry (percent multiply, reciprocal divide by 100,
//  centering), four for the 16-bit radix-2 sample divider, one output.
//  Each stage advances when the next one is empty or moving, so bubbles
//  collapse; req_if stays ready while a response waits and a stage is empty.
//  Reset empties all stages and loads the register defaults. When the
//  receiver stalls, the response beat holds and the pipe fills, then
//  req_if.ready drops; nothing is lost or repeated.
module video_crop_sample_key_mapper_unit #(
   parameter int MAX_DIM = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   vcskm_chan_if.sink                        req_if,
   vcskm_chan_if.source                      rsp_if,
   input  logic                              csr_wr_en,
   input  logic [vcskm_pkg::CsrIdxW-1:0]     csr_index,
   input  logic [vcskm_pkg::CsrDataW-1:0]    csr_wdata
);

   localparam int Last = vcskm_pkg::NumStages - 1;
   localparam logic [vcskm_pkg::DimW+1:0] MaxDimV = (vcskm_pkg::DimW + 2)'(MAX_DIM);

   logic [vcskm_pkg::DimW-1:0]        buf_w_ff, buf_h_ff;
   logic [vcskm_pkg::PctW-1:0]        left_ff, right_ff, top_ff, bottom_ff, spacing_ff;
   logic signed [vcskm_pkg::KeyW-1:0] key_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_w_ff   <= 13'd1;
         buf_h_ff   <= 13'd1;
         left_ff    <= 7'd0;
         right_ff   <= 7'd100;
         top_ff     <= 7'd100;
         bottom_ff  <= 7'd0;
         key_ff     <= -11'sd1;
         spacing_ff <= 7'd0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            vcskm_pkg::CsrBufferWidth:   buf_w_ff   <= csr_wdata;
            vcskm_pkg::CsrBufferHeight:  buf_h_ff   <= csr_wdata;
            vcskm_pkg::CsrCropLeft:      left_ff    <= csr_wdata[vcskm_pkg::PctW-1:0];
            vcskm_pkg::CsrCropRight:     right_ff   <= csr_wdata[vcskm_pkg::PctW-1:0];
            vcskm_pkg::CsrCropTop:       top_ff     <= csr_wdata[vcskm_pkg::PctW-1:0];
            vcskm_pkg::CsrCropBottom:    bottom_ff  <= csr_wdata[vcskm_pkg::PctW-1:0];
            vcskm_pkg::CsrKeyLevel:      key_ff     <= $signed(csr_wdata[vcskm_pkg::KeyW-1:0]);
            vcskm_pkg::CsrSampleSpacing: spacing_ff <= csr_wdata[vcskm_pkg::PctW-1:0];
            default: ;
         endcase
      end
   end

   vcskm_pkg::cfg_type cfg;

   always_comb begin
      cfg.buf_w       = ({2'b00, buf_w_ff} > MaxDimV) ? MaxDimV[vcskm_pkg::DimW-1:0] : buf_w_ff;
      cfg.buf_h       = ({2'b00, buf_h_ff} > MaxDimV) ? MaxDimV[vcskm_pkg::DimW-1:0] : buf_h_ff;
      cfg.crop_left   = left_ff;
      cfg.crop_right  = right_ff;
      cfg.crop_top    = top_ff;
      cfg.crop_bottom = bottom_ff;
      cfg.key_level   = key_ff;
      cfg.spacing     = spacing_ff;
   end

   // pipeline control
   logic [Last:0] valid_ff, valid_in, rdy;
   logic          keep_final;

   always_comb begin
      for (int k = Last; k >= 0; k--) begin
         if (k == Last) rdy[k] = !valid_ff[k] || rsp_if.ready;
         else           rdy[k] = !valid_ff[k] || rdy[k+1];
      end
      for (int k = 0; k <= Last; k++) begin
         if (k == 0)         valid_in[k] = req_if.valid;
         else if (k == Last) valid_in[k] = valid_ff[k-1] && keep_final;
         else                valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k <= Last; k++) begin
            if (rdy[k]) valid_ff[k] <= valid_in[k];
         end
      end
   end

   assign req_if.ready = rdy[0];

   vcskm_pkg::geo_type     geo;
   vcskm_pkg::div_res_type res;

   vcskm_geom u_geom (
      .clock    (clock),
      .cfg      (cfg),
      .stage_en (rdy[vcskm_pkg::GeoStages-1:0]),
      .req_data (req_if.data),
      .geo      (geo)
   );

   vcskm_div u_div (
      .clock    (clock),
      .divisor  (spacing_ff),
      .stage_en (rdy[vcskm_pkg::GeoStages+vcskm_pkg::DivStages-1:vcskm_pkg::GeoStages]),
      .geo_in   (geo),
      .res      (res)
   );

   // final bounds test and output register
   logic [vcskm_pkg::GeoW-1:0] bw_w, bh_w;
   logic                       ok_sample, ok_normal;
   vcskm_pkg::rsp_type         rsp_ff, rsp_in;

   always_comb begin
      bw_w      = {3'b000, cfg.buf_w};
      bh_w      = {3'b000, cfg.buf_h};
      ok_sample = !res.side.neg_s && (res.rem_x == '0) && (res.rem_y == '0)
               && (res.quot_x < bw_w) && (res.quot_y < bh_w);
      ok_normal = res.side.ok_n && (res.side.dx_n < bw_w) && (res.side.dy_n < bh_w);
      keep_final = res.side.keep && ((spacing_ff != '0) ? ok_sample : ok_normal);
      rsp_in.dest_x    = (spacing_ff != '0) ? res.quot_x[vcskm_pkg::CoordW-1:0]
                                            : res.side.dx_n[vcskm_pkg::CoordW-1:0];
      rsp_in.dest_y    = (spacing_ff != '0) ? res.quot_y[vcskm_pkg::CoordW-1:0]
                                            : res.side.dy_n[vcskm_pkg::CoordW-1:0];
      rsp_in.out_red   = res.side.red;
      rsp_in.out_green = res.side.green;
      rsp_in.out_blue  = res.side.blue;
   end

   always_ff @(posedge clock) begin
      if (rdy[Last]) rsp_ff <= rsp_in;
   end

   assign rsp_if.valid = valid_ff[Last];
   assign rsp_if.data  = rsp_ff;

endmodule

>>> rtl/core/vcskm_monitor.sv
// Port-level assertions for the mapper top level, attached by bind.
// Depends on vcskm_pkg and video_crop_sample_key_mapper_unit.
module vcskm_monitor (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input vcskm_pkg::rsp_type             rsp_data,
   input logic                           csr_wr_en,
   input logic [vcskm_pkg::CsrIdxW-1:0]  csr_index,
   input logic [vcskm_pkg::CsrDataW-1:0] csr_wdata
);

   logic signed [vcskm_pkg::KeyW-1:0] key_ff;
   logic [vcskm_pkg::SumW-1:0]        rsp_sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= -11'sd1;
      end else if (csr_wr_en && (csr_index == vcskm_pkg::CsrKeyLevel)) begin
         key_ff <= $signed(csr_wdata[vcskm_pkg::KeyW-1:0]);
      end
   end

   assign rsp_sum = {2'b00, rsp_data.out_red} + {2'b00, rsp_data.out_green}
                  + {2'b00, rsp_data.out_blue};

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("pipeline not empty after reset");

   a_ready_when_out_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with output register free");

   a_key_respected: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $signed({2'b00, rsp_sum}) > $signed({key_ff[vcskm_pkg::KeyW-1], key_ff}))
      else $error("keyed pixel reached the response");

endmodule

bind video_crop_sample_key_mapper_unit vcskm_monitor u_monitor (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_if.ready),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_data  (rsp_if.data),
   .csr_wr_en (csr_wr_en),
   .csr_index (csr_index),
   .csr_wdata (csr_wdata)
);
